// ----- hdl/amge_pkg.sv -----
// Shared types, request and status codes for the adjacency matrix graph engine.
package amge_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [9:0] NO_EDGE = 10'd1000;

  localparam logic [3:0] REQ_CLEAR        = 4'd0;
  localparam logic [3:0] REQ_SET_LABEL    = 4'd1;
  localparam logic [3:0] REQ_ADD_EDGE     = 4'd2;
  localparam logic [3:0] REQ_ADJACENT     = 4'd3;
  localparam logic [3:0] REQ_IN_DEGREE    = 4'd4;
  localparam logic [3:0] REQ_FIRST_ADJ    = 4'd5;
  localparam logic [3:0] REQ_NEXT_ADJ     = 4'd6;
  localparam logic [3:0] REQ_NEXT_VERTEX  = 4'd7;
  localparam logic [3:0] REQ_FIRST_VERTEX = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_END       = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_SETLAB,
    DP_SRCH,
    DP_K0,
    DP_FILL,
    DP_WEDGE,
    DP_RD_ADJ,
    DP_RD_COL,
    DP_ROW_INIT,
    DP_RD_ROW,
    DP_RD_LAB0,
    DP_RD_LAB_NEXT,
    DP_RD_LAB_HIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] req;
    logic       found_a;
    logic       found_b;
    logic       row_vld_a;
    logic       i_last;
    logic       n_zero;
    logic       k_lt_n;
    logic       k_lt_max;
    logic       hit_found;
    logic       out_free;
  } sts_t;

endpackage

// ----- hdl/amge_ctrl.sv -----
// Request sequencer: steps the datapath through search, scan and result phases.
module amge_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  amge_pkg::sts_t sts_i,
  output amge_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SRCH,
    S_SDONE,
    S_FILL,
    S_COL,
    S_ROW,
    S_ROW_END,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt       = state_r;
    cmd_o.op        = amge_pkg::DP_NOP;
    cmd_o.out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd_o.op  = amge_pkg::DP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (sts_i.req)
          amge_pkg::REQ_CLEAR: begin
            cmd_o.op  = amge_pkg::DP_CLEAR;
            state_nxt = S_FINISH;
          end
          amge_pkg::REQ_SET_LABEL: begin
            cmd_o.op  = amge_pkg::DP_SETLAB;
            state_nxt = S_FINISH;
          end
          amge_pkg::REQ_FIRST_VERTEX: begin
            if (!sts_i.n_zero) cmd_o.op = amge_pkg::DP_RD_LAB0;
            state_nxt = S_FINISH;
          end
          default: begin
            if (sts_i.req inside {[amge_pkg::REQ_ADD_EDGE:amge_pkg::REQ_NEXT_VERTEX]}) begin
              state_nxt = S_SRCH;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        endcase
      end
      S_SRCH: begin
        if (sts_i.k_lt_n) cmd_o.op = amge_pkg::DP_SRCH;
        else state_nxt = S_SDONE;
      end
      S_SDONE: begin
        state_nxt = S_FINISH;
        case (sts_i.req)
          amge_pkg::REQ_ADD_EDGE: begin
            if (sts_i.found_a && sts_i.found_b) begin
              if (sts_i.row_vld_a) begin
                cmd_o.op = amge_pkg::DP_WEDGE;
              end else begin
                // Row not written since the last clear: lay down its reset values first.
                cmd_o.op  = amge_pkg::DP_K0;
                state_nxt = S_FILL;
              end
            end
          end
          amge_pkg::REQ_ADJACENT: begin
            if (sts_i.found_a && sts_i.found_b) cmd_o.op = amge_pkg::DP_RD_ADJ;
          end
          amge_pkg::REQ_IN_DEGREE: begin
            if (sts_i.found_a) begin
              cmd_o.op  = amge_pkg::DP_K0;
              state_nxt = S_COL;
            end
          end
          amge_pkg::REQ_FIRST_ADJ: begin
            if (sts_i.found_a) begin
              cmd_o.op  = amge_pkg::DP_ROW_INIT;
              state_nxt = S_ROW;
            end
          end
          amge_pkg::REQ_NEXT_ADJ: begin
            if (sts_i.found_a && sts_i.found_b) begin
              cmd_o.op  = amge_pkg::DP_ROW_INIT;
              state_nxt = S_ROW;
            end
          end
          amge_pkg::REQ_NEXT_VERTEX: begin
            if (sts_i.found_a && !sts_i.i_last) cmd_o.op = amge_pkg::DP_RD_LAB_NEXT;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FILL: begin
        if (sts_i.k_lt_max) begin
          cmd_o.op = amge_pkg::DP_FILL;
        end else begin
          cmd_o.op  = amge_pkg::DP_WEDGE;
          state_nxt = S_FINISH;
        end
      end
      S_COL: begin
        if (sts_i.k_lt_n) cmd_o.op = amge_pkg::DP_RD_COL;
        else state_nxt = S_FINISH;
      end
      S_ROW: begin
        if (sts_i.k_lt_n) cmd_o.op = amge_pkg::DP_RD_ROW;
        else state_nxt = S_ROW_END;
      end
      S_ROW_END: begin
        if (sts_i.hit_found) cmd_o.op = amge_pkg::DP_RD_LAB_HIT;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

// ----- hdl/amge_dp.sv -----
// Datapath: label table, weight matrix, search and scan registers, result register.
module amge_dp #(
  parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [4:0]     cfg_vertex_count,
  input  logic [3:0]     in_req_type,
  input  logic [3:0]     in_slot_index,
  input  logic [7:0]     in_label_a,
  input  logic [7:0]     in_label_b,
  input  logic [9:0]     in_edge_weight,
  input  amge_pkg::cmd_t cmd_i,
  output amge_pkg::sts_t sts_o,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [1:0]     out_status,
  output logic           out_is_adjacent,
  output logic [4:0]     out_degree,
  output logic [7:0]     out_label_out
);

  localparam int IW     = $clog2(MAX_VERTICES);
  localparam int KW     = $clog2(MAX_VERTICES + 1);
  localparam int CW     = (KW > 5) ? KW : 5;
  localparam int SW     = (KW > 4) ? KW : 4;
  localparam int AW     = 2 * IW;
  localparam int MDEPTH = 1 << AW;

  typedef enum logic [1:0] {RK_NONE, RK_SRCH, RK_COL, RK_ROW} rd_kind_t;

  // Configuration and request capture.
  logic [4:0] vc_r;
  logic [3:0] req_r;
  logic [3:0] slot_r;
  logic [7:0] la_r, lb_r;
  logic [9:0] w_r;

  // Search and scan state.
  logic [KW-1:0]           k_r;
  logic                    fa_r, fb_r, hit_found_r;
  logic [IW-1:0]           ia_r, ib_r, hit_r, krd_r;
  logic [4:0]              deg_r;
  logic [MAX_VERTICES-1:0] row_vld_r;
  rd_kind_t                rk_r, rk_nxt;

  // Memories and their read registers.
  logic [7:0] lab_mem [MAX_VERTICES];
  logic [9:0] mat_mem [MDEPTH];
  logic [7:0] lab_q_r;
  logic [9:0] mat_q_r;
  logic [IW-1:0] mrd_row_r, mrd_col_r;
  logic          mrd_vld_r;

  logic          out_valid_r, out_adj_r;
  logic [1:0]    out_status_r;
  logic [4:0]    out_degree_r;
  logic [7:0]    out_label_r;

  logic [KW-1:0] n;
  logic [SW-1:0] slot_ext;
  logic          slot_ok;
  logic          lab_we, lab_re, mat_we, mat_re;
  logic [IW-1:0] lab_raddr, mrow, mcol, mwcol;
  logic [9:0]    mat_wdata, w_sat, eff_w;
  logic          edge_here, i_last;
  logic [1:0]    res_status;
  logic          res_adj;
  logic [4:0]    res_deg;
  logic [7:0]    res_lab;

  assign n = (CW'(vc_r) > CW'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : KW'(CW'(vc_r));
  assign slot_ext = SW'(slot_r);
  assign slot_ok  = slot_ext < SW'(MAX_VERTICES);
  assign w_sat    = (w_r > amge_pkg::NO_EDGE) ? amge_pkg::NO_EDGE : w_r;
  assign i_last   = (KW'(ia_r) + KW'(1)) >= n;

  // A row not written since the last clear reads as its reset values.
  assign eff_w = mrd_vld_r ? mat_q_r :
                 ((mrd_row_r == mrd_col_r) ? 10'd0 : amge_pkg::NO_EDGE);
  assign edge_here = (eff_w != amge_pkg::NO_EDGE);

  always_comb begin
    lab_we    = (cmd_i.op == amge_pkg::DP_SETLAB) && slot_ok;
    lab_re    = cmd_i.op inside {amge_pkg::DP_SRCH, amge_pkg::DP_RD_LAB0,
                                 amge_pkg::DP_RD_LAB_NEXT, amge_pkg::DP_RD_LAB_HIT};
    mat_we    = cmd_i.op inside {amge_pkg::DP_FILL, amge_pkg::DP_WEDGE};
    mat_re    = cmd_i.op inside {amge_pkg::DP_RD_ADJ, amge_pkg::DP_RD_COL,
                                 amge_pkg::DP_RD_ROW};
    lab_raddr = k_r[IW-1:0];
    mrow      = ia_r;
    mcol      = ib_r;
    case (cmd_i.op)
      amge_pkg::DP_RD_LAB0:     lab_raddr = '0;
      amge_pkg::DP_RD_LAB_NEXT: lab_raddr = ia_r + IW'(1);
      amge_pkg::DP_RD_LAB_HIT:  lab_raddr = hit_r;
      amge_pkg::DP_RD_COL: begin
        mrow = k_r[IW-1:0];
        mcol = ia_r;
      end
      amge_pkg::DP_RD_ROW:      mcol = k_r[IW-1:0];
      default: ;
    endcase
    if (cmd_i.op == amge_pkg::DP_FILL) begin
      mwcol     = k_r[IW-1:0];
      mat_wdata = (k_r[IW-1:0] == ia_r) ? 10'd0 : amge_pkg::NO_EDGE;
    end else begin
      mwcol     = ib_r;
      mat_wdata = w_sat;
    end
    case (cmd_i.op)
      amge_pkg::DP_SRCH:   rk_nxt = RK_SRCH;
      amge_pkg::DP_RD_COL: rk_nxt = RK_COL;
      amge_pkg::DP_RD_ROW: rk_nxt = RK_ROW;
      default:             rk_nxt = RK_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[IW'(slot_ext)] <= la_r;
    if (lab_re) lab_q_r <= lab_mem[lab_raddr];
  end

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[{ia_r, mwcol}] <= mat_wdata;
    if (mat_re) begin
      mat_q_r   <= mat_mem[{mrow, mcol}];
      mrd_row_r <= mrow;
      mrd_col_r <= mcol;
      mrd_vld_r <= row_vld_r[mrow];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == amge_pkg::DP_LOAD) begin
      req_r  <= in_req_type;
      slot_r <= in_slot_index;
      la_r   <= in_label_a;
      lb_r   <= in_label_b;
      w_r    <= in_edge_weight;
    end
    if (cmd_i.op == amge_pkg::DP_SRCH) krd_r <= k_r[IW-1:0];
    if (cmd_i.out_load) begin
      out_status_r <= res_status;
      out_adj_r    <= res_adj;
      out_degree_r <= res_deg;
      out_label_r  <= res_lab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= '0;
      k_r         <= '0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
      ia_r        <= '0;
      ib_r        <= '0;
      hit_found_r <= 1'b0;
      hit_r       <= '0;
      deg_r       <= '0;
      row_vld_r   <= '0;
      rk_r        <= RK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) vc_r <= cfg_vertex_count;
      rk_r <= rk_nxt;
      case (cmd_i.op)
        amge_pkg::DP_LOAD, amge_pkg::DP_K0: k_r <= '0;
        amge_pkg::DP_SRCH, amge_pkg::DP_FILL, amge_pkg::DP_RD_COL, amge_pkg::DP_RD_ROW: begin
          k_r <= k_r + KW'(1);
        end
        amge_pkg::DP_ROW_INIT: begin
          k_r <= (req_r == amge_pkg::REQ_NEXT_ADJ) ? KW'(ib_r) + KW'(1) : '0;
        end
        amge_pkg::DP_CLEAR: row_vld_r <= '0;
        amge_pkg::DP_WEDGE: row_vld_r[ia_r] <= 1'b1;
        default: ;
      endcase
      // Read data is examined in the cycle after its address was issued.
      if (cmd_i.op == amge_pkg::DP_LOAD) begin
        fa_r        <= 1'b0;
        fb_r        <= 1'b0;
        hit_found_r <= 1'b0;
        deg_r       <= '0;
      end else begin
        case (rk_r)
          RK_SRCH: begin
            if (!fa_r && (lab_q_r == la_r)) begin
              fa_r <= 1'b1;
              ia_r <= krd_r;
            end
            if (!fb_r && (lab_q_r == lb_r)) begin
              fb_r <= 1'b1;
              ib_r <= krd_r;
            end
          end
          RK_COL: begin
            if (edge_here) deg_r <= deg_r + 5'd1;
          end
          RK_ROW: begin
            if (!hit_found_r && (mrd_col_r != ia_r) && edge_here) begin
              hit_found_r <= 1'b1;
              hit_r       <= mrd_col_r;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    res_status = amge_pkg::ST_OK;
    res_adj    = 1'b0;
    res_deg    = '0;
    res_lab    = '0;
    case (req_r)
      amge_pkg::REQ_ADD_EDGE: begin
        if (!(fa_r && fb_r)) res_status = amge_pkg::ST_NOT_FOUND;
      end
      amge_pkg::REQ_ADJACENT: begin
        if (!(fa_r && fb_r)) res_status = amge_pkg::ST_NOT_FOUND;
        else res_adj = edge_here;
      end
      amge_pkg::REQ_IN_DEGREE: begin
        if (!fa_r) res_status = amge_pkg::ST_NOT_FOUND;
        else res_deg = deg_r;
      end
      amge_pkg::REQ_FIRST_ADJ, amge_pkg::REQ_NEXT_ADJ: begin
        if (!fa_r || ((req_r == amge_pkg::REQ_NEXT_ADJ) && !fb_r)) begin
          res_status = amge_pkg::ST_NOT_FOUND;
        end else if (hit_found_r) begin
          res_lab = lab_q_r;
        end else begin
          res_status = amge_pkg::ST_END;
        end
      end
      amge_pkg::REQ_NEXT_VERTEX: begin
        if (!fa_r) res_status = amge_pkg::ST_NOT_FOUND;
        else if (i_last) res_status = amge_pkg::ST_END;
        else res_lab = lab_q_r;
      end
      amge_pkg::REQ_FIRST_VERTEX: begin
        if (n == '0) res_status = amge_pkg::ST_END;
        else res_lab = lab_q_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.req       = req_r;
    sts_o.found_a   = fa_r;
    sts_o.found_b   = fb_r;
    sts_o.row_vld_a = row_vld_r[ia_r];
    sts_o.i_last    = i_last;
    sts_o.n_zero    = (n == '0);
    sts_o.k_lt_n    = k_r < n;
    sts_o.k_lt_max  = k_r < KW'(MAX_VERTICES);
    sts_o.hit_found = hit_found_r;
    sts_o.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_is_adjacent = out_adj_r;
  assign out_degree      = out_degree_r;
  assign out_label_out   = out_label_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a word not yet taken");

  a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.op == amge_pkg::DP_CLEAR) |=> (row_vld_r == '0))
    else $error("row valid flags survive a clear");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != amge_pkg::ST_OK)) |->
      (!out_adj_r && (out_degree_r == 5'd0) && (out_label_r == 8'd0)))
    else $error("failed result carries nonzero fields");

  a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rk_r == RK_COL) |-> (CW'(deg_r) < CW'(n)))
    else $error("in-degree count exceeds entries scanned");
`endif

endmodule

// ----- hdl/adjacency_matrix_graph_engine.sv -----
// Top level of the adjacency matrix graph engine: sequencer plus datapath.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+------------------------------------------
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_vertex_count
//  in      | in  | in_valid/in_ready    | req_type, slot_index, label_a, label_b, weight
//  out     | out | out_valid/out_ready  | status, is_adjacent, degree, label_out
//
// Clear and set label need no search; label lookups, adjacency and next vertex search
// the n label entries, in-degree and neighbour walks then scan a matrix column or row
// (n = vertices in use). An add edge into a row untouched since the last clear first
// fills that row. The label table and the weight matrix each serve one read per cycle.
// Reset (rst_n low at a clock edge) empties the graph at once through per-row valid flags.
// A finished word waits in the output register while the next request is taken.
module adjacency_matrix_graph_engine #(
  parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_vertex_count,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_req_type,
  input  logic [3:0] in_slot_index,
  input  logic [7:0] in_label_a,
  input  logic [7:0] in_label_b,
  input  logic [9:0] in_edge_weight,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_is_adjacent,
  output logic [4:0] out_degree,
  output logic [7:0] out_label_out
);

  amge_pkg::cmd_t cmd;
  amge_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  amge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  amge_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_vertex_count (cfg_vertex_count),
    .in_req_type      (in_req_type),
    .in_slot_index    (in_slot_index),
    .in_label_a       (in_label_a),
    .in_label_b       (in_label_b),
    .in_edge_weight   (in_edge_weight),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_is_adjacent  (out_is_adjacent),
    .out_degree       (out_degree),
    .out_label_out    (out_label_out)
  );

endmodule
